// File: design/mts_pkg.sv
// Shared types, codes and sizes for the MIDI track event sequencer.
// Used by every module of the block but the RAM and by its port checker; depends on nothing.
package mts_pkg;

    // Storage sizes and the widths that follow from them.
    localparam int TRACK_BYTES = 65536;
    localparam int NOTE_SLOTS  = 32;
    localparam int ADDR_W      = $clog2(TRACK_BYTES);
    localparam int POS_W       = ADDR_W + 1;
    localparam int SLOT_W      = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int SCAN_W      = $clog2(NOTE_SLOTS + 1);

    // Fixed field widths of the stream items.
    localparam int LEN_W      = 17;
    localparam int TICK_W     = 31;
    localparam int DELAY_W    = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;

    // Track byte codes.
    localparam logic [7:0] DATA_MASK    = 8'h7f;
    localparam logic [7:0] STATUS_SYSEX = 8'hf0;
    localparam logic [7:0] STATUS_META  = 8'hff;
    localparam logic [7:0] META_END     = 8'h2f;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam int         HDR_BYTES    = 3;

    // Status nibbles of channel messages.
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'ha;
    localparam logic [3:0] NIB_CONTROL   = 4'hb;
    localparam logic [3:0] NIB_PROGRAM   = 4'hc;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hd;
    localparam logic [3:0] NIB_PITCH     = 4'he;
    localparam logic [3:0] NIB_SYSTEM    = 4'hf;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_FETCH   = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_WAIT     = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_NOTE_ON  = 3'd2,
        KIND_CHAN_MSG = 3'd3,
        KIND_SYSEX    = 3'd4,
        KIND_TEMPO    = 3'd5,
        KIND_END      = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADV_FIND,
        ST_ADV_WR,
        ST_F_START,
        ST_SCAN_FIND,
        ST_SCAN_CHK,
        ST_EVT,
        ST_SX_DATA,
        ST_MIN_FIND,
        ST_MIN_CHK,
        ST_HDR0,
        ST_HDR1,
        ST_DISPATCH,
        ST_D1,
        ST_VL,
        ST_VL_D,
        ST_NOTE_ALLOC,
        ST_FLEN,
        ST_META,
        ST_TEMPO,
        ST_TEMPO_D,
        ST_GAP,
        ST_GAP_D,
        ST_EMIT
    } t_state;

    // One result item.
    typedef struct packed {
        t_kind             kind;
        logic [3:0]        channel;
        logic [7:0]        status;
        logic [7:0]        first;
        logic [7:0]        second;
        logic [23:0]       tempo;
        logic [TICK_W-1:0] wait_ticks;
        logic              last;
        logic              dropped;
    } t_result;

    // One pending note entry of the slot memory.
    typedef struct packed {
        logic [3:0]                 channel;
        logic [7:0]                 note;
        logic signed [DELAY_W-1:0]  delay;
    } t_slot;

endpackage

// File: design/mts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the track bytes and the pending note table; no dependencies.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: design/mts_engine.sv
// Sequencing engine: decodes track bytes and keeps the pending note table.
// Depends on mts_pkg and instantiates mts_ram for track and slot storage.
module mts_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  mts_pkg::t_func              i_func,
    input  logic [15:0]                 i_load_address,
    input  logic [7:0]                  i_load_byte,
    input  logic [mts_pkg::TICK_W-1:0]  i_advance_ticks,
    input  logic [mts_pkg::POS_W-1:0]   i_limit,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output mts_pkg::t_result            o_res
);

    localparam logic PHASE_SCAN   = 1'b0;
    localparam logic PHASE_EVENTS = 1'b1;
    localparam int   SLOT_DW      = $bits(mts_pkg::t_slot);

    // Registers and next values.
    mts_pkg::t_state                  r_state, n_state;
    mts_pkg::t_state                  r_ret, n_ret;
    logic [mts_pkg::POS_W-1:0]        r_pos, n_pos;
    logic signed [mts_pkg::DELAY_W-1:0] r_edelay, n_edelay;
    logic                             r_ended, n_ended;
    logic                             r_phase, n_phase;
    logic [mts_pkg::SCAN_W-1:0]       r_scan, n_scan;
    logic [mts_pkg::SCAN_W-1:0]       r_idx, n_idx;
    logic [mts_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic [31:0]                      r_sxrem, n_sxrem;
    logic [31:0]                      r_vl, n_vl;
    logic [7:0]                       r_st, n_st;
    logic [7:0]                       r_d0, n_d0;
    logic [23:0]                      r_tempo, n_tempo;
    logic [1:0]                       r_cnt, n_cnt;
    logic [mts_pkg::TICK_W-1:0]       r_t, n_t;
    logic                             r_restart, n_restart;
    logic signed [mts_pkg::DELAY_W-1:0] r_min, n_min;
    mts_pkg::t_result                 r_res, n_res;
    logic [mts_pkg::NOTE_SLOTS-1:0]   r_valid, n_valid;
    logic                             r_rd_ok;

    // Memory port signals.
    logic                             trk_we;
    logic [mts_pkg::POS_W-1:0]        trk_raddr;
    logic [7:0]                       trk_q;
    logic                             slot_re;
    logic [mts_pkg::SLOT_W-1:0]       slot_raddr;
    logic                             slot_we;
    logic [mts_pkg::SLOT_W-1:0]       slot_waddr;
    mts_pkg::t_slot                   slot_wdata;
    logic [SLOT_DW-1:0]               slot_rdata;
    mts_pkg::t_slot                   slot_q;

    // Derived values.
    logic [7:0]                       rbyte;
    logic [32:0]                      len_end;
    logic [mts_pkg::SCAN_W-1:0]       find_start;
    logic [mts_pkg::SLOT_W:0]         fv;
    logic [mts_pkg::SLOT_W:0]         fi;
    logic                             item_take;
    logic [mts_pkg::POS_W-1:0]        pos_inc;

    // Lowest set bit of a vector at or above a start index.
    function automatic logic [mts_pkg::SLOT_W:0] first_from(
        input logic [mts_pkg::NOTE_SLOTS-1:0] vec,
        input logic [mts_pkg::SCAN_W-1:0]     start
    );
        logic [mts_pkg::SLOT_W:0] res;
        res = '0;
        for (int i = mts_pkg::NOTE_SLOTS - 1; i >= 0; i--) begin
            if (vec[i] && (i >= int'(start))) begin
                res = {1'b1, mts_pkg::SLOT_W'(i)};
            end
        end
        return res;
    endfunction

    // Delay minus ticks, held at the most negative value.
    function automatic logic signed [mts_pkg::DELAY_W-1:0] sub_sat(
        input logic signed [mts_pkg::DELAY_W-1:0] d,
        input logic [mts_pkg::TICK_W-1:0]         t
    );
        logic [mts_pkg::DELAY_W:0] diff;
        diff = {d[mts_pkg::DELAY_W-1], d} - {2'b00, t};
        if (diff[mts_pkg::DELAY_W] != diff[mts_pkg::DELAY_W-1]) begin
            return {1'b1, {(mts_pkg::DELAY_W-1){1'b0}}};
        end
        return diff[mts_pkg::DELAY_W-1:0];
    endfunction

    // Note duration, held at the largest positive delay.
    function automatic logic signed [mts_pkg::DELAY_W-1:0] dur_sat(input logic [31:0] v);
        if (v[31]) begin
            return {1'b0, {(mts_pkg::DELAY_W-1){1'b1}}};
        end
        return v;
    endfunction

    mts_ram #(
        .WIDTH (8),
        .DEPTH (mts_pkg::TRACK_BYTES)
    ) u_track_ram (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (mts_pkg::ADDR_W'(i_load_address)),
        .i_wdata (i_load_byte),
        .i_re    (1'b1),
        .i_raddr (trk_raddr[mts_pkg::ADDR_W-1:0]),
        .o_rdata (trk_q)
    );

    mts_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (mts_pkg::NOTE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // Shared views of the read data and the slot searches.
    assign slot_q     = mts_pkg::t_slot'(slot_rdata);
    assign rbyte      = r_rd_ok ? trk_q : 8'h00;
    assign len_end    = {1'b0, 32'(r_pos)} + {1'b0, r_vl};
    assign pos_inc    = r_pos + mts_pkg::POS_W'(1);
    assign find_start = (r_state == mts_pkg::ST_SCAN_FIND) ? r_scan : r_idx;
    assign fv         = first_from(r_valid, find_start);
    assign fi         = first_from(~r_valid, '0);
    assign item_take  = i_item_valid && (r_state == mts_pkg::ST_IDLE);

    // Next state and data registers.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_pos     = r_pos;
        n_edelay  = r_edelay;
        n_ended   = r_ended;
        n_phase   = r_phase;
        n_scan    = r_scan;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_sxrem   = r_sxrem;
        n_vl      = r_vl;
        n_st      = r_st;
        n_d0      = r_d0;
        n_tempo   = r_tempo;
        n_cnt     = r_cnt;
        n_t       = r_t;
        n_restart = r_restart;
        n_min     = r_min;
        n_res     = r_res;
        n_valid   = r_valid;

        unique case (r_state)
            mts_pkg::ST_IDLE: begin
                if (item_take) begin
                    unique case (i_func)
                        mts_pkg::FUNC_LOAD: begin
                            n_state = mts_pkg::ST_IDLE;
                        end
                        mts_pkg::FUNC_ADVANCE: begin
                            if (!r_ended) begin
                                n_edelay  = sub_sat(r_edelay, i_advance_ticks);
                                n_t       = i_advance_ticks;
                                n_restart = 1'b0;
                                n_idx     = '0;
                                n_state   = mts_pkg::ST_ADV_FIND;
                            end
                        end
                        mts_pkg::FUNC_FETCH: begin
                            n_state = mts_pkg::ST_F_START;
                        end
                        mts_pkg::FUNC_RESTART: begin
                            n_pos     = '0;
                            n_edelay  = '0;
                            n_ended   = 1'b0;
                            n_phase   = PHASE_SCAN;
                            n_scan    = '0;
                            n_sxrem   = '0;
                            n_restart = 1'b1;
                            n_idx     = '0;
                            n_state   = mts_pkg::ST_ADV_FIND;
                        end
                        default: begin
                            n_state = mts_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Sweep over pending notes for an advance or a restart.
            mts_pkg::ST_ADV_FIND: begin
                if (!fv[mts_pkg::SLOT_W]) begin
                    n_state = mts_pkg::ST_IDLE;
                end else begin
                    n_slot  = fv[mts_pkg::SLOT_W-1:0];
                    n_idx   = mts_pkg::SCAN_W'(fv[mts_pkg::SLOT_W-1:0]) + mts_pkg::SCAN_W'(1);
                    n_state = mts_pkg::ST_ADV_WR;
                end
            end
            mts_pkg::ST_ADV_WR: begin
                n_state = mts_pkg::ST_ADV_FIND;
            end

            mts_pkg::ST_F_START: begin
                n_res = '0;
                if (r_ended) begin
                    n_res.kind = mts_pkg::KIND_END;
                    n_state    = mts_pkg::ST_EMIT;
                end else if (r_phase == PHASE_SCAN) begin
                    n_state = mts_pkg::ST_SCAN_FIND;
                end else begin
                    n_state = mts_pkg::ST_EVT;
                end
            end

            // Note-off scan in slot order.
            mts_pkg::ST_SCAN_FIND: begin
                if (!fv[mts_pkg::SLOT_W]) begin
                    n_phase = PHASE_EVENTS;
                    n_scan  = '0;
                    n_state = mts_pkg::ST_EVT;
                end else begin
                    n_slot  = fv[mts_pkg::SLOT_W-1:0];
                    n_scan  = mts_pkg::SCAN_W'(fv[mts_pkg::SLOT_W-1:0]) + mts_pkg::SCAN_W'(1);
                    n_state = mts_pkg::ST_SCAN_CHK;
                end
            end
            mts_pkg::ST_SCAN_CHK: begin
                if (slot_q.delay[mts_pkg::DELAY_W-1] || (slot_q.delay == '0)) begin
                    n_valid[r_slot] = 1'b0;
                    n_res           = '0;
                    n_res.kind      = mts_pkg::KIND_NOTE_OFF;
                    n_res.channel   = slot_q.channel;
                    n_res.first     = slot_q.note;
                    n_state         = mts_pkg::ST_EMIT;
                end else begin
                    n_state = mts_pkg::ST_SCAN_FIND;
                end
            end

            // Top of the event loop.
            mts_pkg::ST_EVT: begin
                n_res = '0;
                if (r_sxrem != '0) begin
                    n_state = mts_pkg::ST_SX_DATA;
                end else if (r_edelay > 0) begin
                    n_min   = r_edelay;
                    n_idx   = '0;
                    n_state = mts_pkg::ST_MIN_FIND;
                end else if (({1'b0, r_pos} + (mts_pkg::POS_W + 1)'(mts_pkg::HDR_BYTES))
                             > {1'b0, i_limit}) begin
                    n_ended    = 1'b1;
                    n_res.kind = mts_pkg::KIND_END;
                    n_state    = mts_pkg::ST_EMIT;
                end else begin
                    n_state = mts_pkg::ST_HDR0;
                end
            end

            mts_pkg::ST_SX_DATA: begin
                n_pos      = pos_inc;
                n_sxrem    = r_sxrem - 32'd1;
                n_res.kind = mts_pkg::KIND_SYSEX;
                n_res.first = rbyte;
                n_res.last = (r_sxrem == 32'd1);
                if (r_sxrem == 32'd1) begin
                    n_ret   = mts_pkg::ST_EMIT;
                    n_state = mts_pkg::ST_GAP;
                end else begin
                    n_state = mts_pkg::ST_EMIT;
                end
            end

            // Least remaining delay over the event and the pending notes.
            mts_pkg::ST_MIN_FIND: begin
                if (!fv[mts_pkg::SLOT_W]) begin
                    n_res            = '0;
                    n_res.kind       = mts_pkg::KIND_WAIT;
                    n_res.wait_ticks = r_min[mts_pkg::DELAY_W-1] ? '0 : r_min[mts_pkg::TICK_W-1:0];
                    n_phase          = PHASE_SCAN;
                    n_state          = mts_pkg::ST_EMIT;
                end else begin
                    n_idx   = mts_pkg::SCAN_W'(fv[mts_pkg::SLOT_W-1:0]) + mts_pkg::SCAN_W'(1);
                    n_state = mts_pkg::ST_MIN_CHK;
                end
            end
            mts_pkg::ST_MIN_CHK: begin
                if ($signed(slot_q.delay) < $signed(r_min)) begin
                    n_min = slot_q.delay;
                end
                n_state = mts_pkg::ST_MIN_FIND;
            end

            // Event header: status and first data byte.
            mts_pkg::ST_HDR0: begin
                n_st    = rbyte;
                n_pos   = pos_inc;
                n_state = mts_pkg::ST_HDR1;
            end
            mts_pkg::ST_HDR1: begin
                n_d0    = rbyte;
                n_pos   = pos_inc;
                n_state = mts_pkg::ST_DISPATCH;
            end

            mts_pkg::ST_DISPATCH: begin
                n_vl = '0;
                unique case (r_st[7:4])
                    mts_pkg::NIB_NOTE_OFF, mts_pkg::NIB_POLY_AT, mts_pkg::NIB_CONTROL,
                    mts_pkg::NIB_PITCH, mts_pkg::NIB_NOTE_ON: begin
                        n_state = mts_pkg::ST_D1;
                    end
                    mts_pkg::NIB_PROGRAM, mts_pkg::NIB_CHAN_AT: begin
                        n_res.kind    = mts_pkg::KIND_CHAN_MSG;
                        n_res.channel = r_st[3:0];
                        n_res.status  = r_st;
                        n_res.first   = r_d0;
                        n_ret         = mts_pkg::ST_EMIT;
                        n_state       = mts_pkg::ST_GAP;
                    end
                    mts_pkg::NIB_SYSTEM: begin
                        if (r_st != mts_pkg::STATUS_META) begin
                            n_pos = r_pos - mts_pkg::POS_W'(1);
                            n_ret = mts_pkg::ST_FLEN;
                        end else begin
                            n_ret = mts_pkg::ST_META;
                        end
                        n_state = mts_pkg::ST_VL;
                    end
                    default: begin
                        n_ret   = mts_pkg::ST_EVT;
                        n_state = mts_pkg::ST_GAP;
                    end
                endcase
            end

            mts_pkg::ST_D1: begin
                n_pos = pos_inc;
                if (r_st[7:4] == mts_pkg::NIB_NOTE_ON) begin
                    n_res.second = rbyte;
                    n_ret        = mts_pkg::ST_NOTE_ALLOC;
                    n_state      = mts_pkg::ST_VL;
                end else begin
                    n_res.kind    = mts_pkg::KIND_CHAN_MSG;
                    n_res.channel = r_st[3:0];
                    n_res.status  = r_st;
                    n_res.first   = r_d0;
                    n_res.second  = rbyte;
                    n_ret         = mts_pkg::ST_EMIT;
                    n_state       = mts_pkg::ST_GAP;
                end
            end

            // Variable-length quantity, one byte per cycle.
            mts_pkg::ST_VL: begin
                n_state = mts_pkg::ST_VL_D;
            end
            mts_pkg::ST_VL_D: begin
                n_pos = pos_inc;
                n_vl  = {r_vl[24:0], rbyte[6:0]};
                if (rbyte[7] && (pos_inc < i_limit)) begin
                    n_state = mts_pkg::ST_VL_D;
                end else begin
                    n_state = r_ret;
                end
            end

            mts_pkg::ST_NOTE_ALLOC: begin
                n_res.kind    = mts_pkg::KIND_NOTE_ON;
                n_res.channel = r_st[3:0];
                n_res.first   = r_d0;
                n_res.dropped = !fi[mts_pkg::SLOT_W];
                if (fi[mts_pkg::SLOT_W]) begin
                    n_valid[fi[mts_pkg::SLOT_W-1:0]] = 1'b1;
                end
                n_ret   = mts_pkg::ST_EMIT;
                n_state = mts_pkg::ST_GAP;
            end

            // System events other than meta.
            mts_pkg::ST_FLEN: begin
                if (len_end >= 33'(i_limit)) begin
                    n_ended    = 1'b1;
                    n_res      = '0;
                    n_res.kind = mts_pkg::KIND_END;
                    n_state    = mts_pkg::ST_EMIT;
                end else if ((r_st == mts_pkg::STATUS_SYSEX) && (r_vl != '0)) begin
                    n_sxrem = r_vl;
                    n_state = mts_pkg::ST_EVT;
                end else begin
                    n_pos   = len_end[mts_pkg::POS_W-1:0];
                    n_ret   = mts_pkg::ST_EVT;
                    n_state = mts_pkg::ST_GAP;
                end
            end

            mts_pkg::ST_META: begin
                if ((r_d0 == mts_pkg::META_END) || (len_end >= 33'(i_limit))) begin
                    n_ended    = 1'b1;
                    n_res      = '0;
                    n_res.kind = mts_pkg::KIND_END;
                    n_state    = mts_pkg::ST_EMIT;
                end else if (r_d0 == mts_pkg::META_TEMPO) begin
                    n_cnt   = '0;
                    n_tempo = '0;
                    n_state = mts_pkg::ST_TEMPO;
                end else begin
                    n_pos   = len_end[mts_pkg::POS_W-1:0];
                    n_ret   = mts_pkg::ST_EVT;
                    n_state = mts_pkg::ST_GAP;
                end
            end

            mts_pkg::ST_TEMPO: begin
                n_state = mts_pkg::ST_TEMPO_D;
            end
            mts_pkg::ST_TEMPO_D: begin
                n_tempo = {r_tempo[15:0], rbyte};
                if (r_cnt == 2'd2) begin
                    n_pos       = len_end[mts_pkg::POS_W-1:0];
                    n_res       = '0;
                    n_res.kind  = mts_pkg::KIND_TEMPO;
                    n_res.tempo = {r_tempo[15:0], rbyte};
                    n_ret       = mts_pkg::ST_EMIT;
                    n_state     = mts_pkg::ST_GAP;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = mts_pkg::ST_TEMPO;
                end
            end

            // Delta gap before the next event.
            mts_pkg::ST_GAP: begin
                n_edelay = '0;
                if (r_pos >= i_limit) begin
                    n_state = r_ret;
                end else begin
                    n_state = mts_pkg::ST_GAP_D;
                end
            end
            mts_pkg::ST_GAP_D: begin
                if (!rbyte[7]) begin
                    n_edelay = r_edelay + mts_pkg::DELAY_W'(rbyte);
                    n_pos    = pos_inc;
                end
                if ((rbyte == mts_pkg::DATA_MASK) && (pos_inc < i_limit)) begin
                    n_state = mts_pkg::ST_GAP_D;
                end else begin
                    n_state = r_ret;
                end
            end

            mts_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = mts_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mts_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshakes and memory ports.
    always_comb begin
        o_item_ready = (r_state == mts_pkg::ST_IDLE);
        o_res_valid  = (r_state == mts_pkg::ST_EMIT);
        o_res        = r_res;

        trk_we = item_take && (i_func == mts_pkg::FUNC_LOAD)
                 && (32'(i_load_address) < 32'(mts_pkg::TRACK_BYTES));

        unique case (r_state)
            mts_pkg::ST_HDR0, mts_pkg::ST_VL_D, mts_pkg::ST_GAP_D: trk_raddr = pos_inc;
            mts_pkg::ST_TEMPO: trk_raddr = r_pos + mts_pkg::POS_W'(r_cnt);
            default:           trk_raddr = r_pos;
        endcase

        slot_re    = ((r_state == mts_pkg::ST_ADV_FIND) || (r_state == mts_pkg::ST_SCAN_FIND)
                      || (r_state == mts_pkg::ST_MIN_FIND)) && fv[mts_pkg::SLOT_W];
        slot_raddr = fv[mts_pkg::SLOT_W-1:0];

        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = slot_q;
        if (r_state == mts_pkg::ST_ADV_WR) begin
            slot_we          = 1'b1;
            slot_wdata.delay = r_restart ? '0 : sub_sat(slot_q.delay, r_t);
        end else if (r_state == mts_pkg::ST_NOTE_ALLOC) begin
            slot_we            = fi[mts_pkg::SLOT_W];
            slot_waddr         = fi[mts_pkg::SLOT_W-1:0];
            slot_wdata.channel = r_st[3:0];
            slot_wdata.note    = r_d0;
            slot_wdata.delay   = dur_sat(r_vl);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::ST_IDLE;
            r_ret   <= mts_pkg::ST_IDLE;
            r_pos   <= '0;
            r_edelay <= '0;
            r_ended <= 1'b0;
            r_phase <= PHASE_SCAN;
            r_scan  <= '0;
            r_sxrem <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pos   <= n_pos;
            r_edelay <= n_edelay;
            r_ended <= n_ended;
            r_phase <= n_phase;
            r_scan  <= n_scan;
            r_sxrem <= n_sxrem;
            r_valid <= n_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_vl      <= n_vl;
        r_st      <= n_st;
        r_d0      <= n_d0;
        r_tempo   <= n_tempo;
        r_cnt     <= n_cnt;
        r_t       <= n_t;
        r_restart <= n_restart;
        r_min     <= n_min;
        r_res     <= n_res;
        r_rd_ok   <= (trk_raddr < i_limit);
    end

endmodule

// File: design/midi_track_event_sequencer.sv
// Top level of the MIDI track event sequencer: stream ports, length register, result register.
// Depends on mts_pkg and mts_engine.
//
//  Channel   | Direction | Carries
//  s_axis    | in        | tuser: func; tdata: load_address, load_byte, advance_ticks
//  m_axis    | out       | tuser: kind; tlast: sysex_last; tdata: result fields
//  cfg       | in        | track_length
//
// A load is taken while the engine is idle. An advance or a restart runs a read-modify-write
// sweep over the slot memory, visiting each pending note. A fetch reads the track bytes of
// its event and visits the pending notes in the note-off scan or in the least-delay search.
// Reset is synchronous and needs no clearing pass. A result waits in the output register
// while the next item is taken; a fetch stalls only when that register is still full.
module midi_track_event_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] load_address, [23:16] load_byte, [54:24] advance_ticks
    input  logic [mts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] channel, [11:4] status_byte, [19:12] first_value, [27:20] second_value,
    // [51:28] tempo_value, [82:52] wait_ticks, [83] note_dropped
    output logic [mts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mts_pkg::LEN_W-1:0]         i_cfg_data
);

    logic [mts_pkg::POS_W-1:0] r_limit;
    logic                      r_out_valid;
    mts_pkg::t_result          r_out;

    logic                      out_free;
    logic                      res_valid;
    mts_pkg::t_result          res;

    // Track length register, held at the memory size.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            if (32'(i_cfg_data) > 32'(mts_pkg::TRACK_BYTES)) begin
                r_limit <= mts_pkg::POS_W'(mts_pkg::TRACK_BYTES);
            end else begin
                r_limit <= mts_pkg::POS_W'(i_cfg_data);
            end
        end
    end

    mts_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (s_axis_tvalid),
        .o_item_ready    (s_axis_tready),
        .i_func          (mts_pkg::t_func'(s_axis_tuser)),
        .i_load_address  (s_axis_tdata[15:0]),
        .i_load_byte     (s_axis_tdata[23:16]),
        .i_advance_ticks (s_axis_tdata[54:24]),
        .i_limit         (r_limit),
        .o_res_valid     (res_valid),
        .i_res_ready     (out_free),
        .o_res           (res)
    );

    // Output register.
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'b0000, r_out.dropped, r_out.wait_ticks, r_out.tempo,
                            r_out.second, r_out.first, r_out.status, r_out.channel};

endmodule

// File: design/mts_checker.sv
// Port-level checks on the result stream of the MIDI track event sequencer.
// Depends on mts_pkg; attached to the top level by the bind statement at the end.
module mts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [mts_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    input logic [2:0]                     i_m_axis_tuser,
    input logic                           i_m_axis_tlast
);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("stalled result changed");

    // The last mark appears only on sysex bytes.
    a_last_sysex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tlast |-> i_m_axis_tuser == 3'(mts_pkg::KIND_SYSEX))
        else $error("last mark on a result other than sysex");

    // A wait result carries only its tick count.
    a_wait_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tuser == 3'(mts_pkg::KIND_WAIT)) |->
            (i_m_axis_tdata[51:0] == '0) && !i_m_axis_tdata[83] && !i_m_axis_tlast)
        else $error("wait result carries stray fields");

endmodule

bind midi_track_event_sequencer mts_checker u_mts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (m_axis_tvalid),
    .i_m_axis_tready (m_axis_tready),
    .i_m_axis_tdata  (m_axis_tdata),
    .i_m_axis_tuser  (m_axis_tuser),
    .i_m_axis_tlast  (m_axis_tlast)
);

// File: bench/mts_checker.sv
// Port checker for the MIDI track event sequencer: tracks its own copy of the track
// player, predicts each result and compares it with what leaves the result channel.
// Depends on mts_pkg.
module mts_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [mts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [mts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [2:0]                     m_axis_tuser,
    input  logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [mts_pkg::LEN_W-1:0]      i_cfg_data,
    output int                             o_fail,
    output int                             o_pending
);
    import mts_pkg::*;

    localparam longint DELAY_TOP    = 64'sd2147483647;
    localparam longint DELAY_BOTTOM = -64'sd2147483648;

    // Mirror of the player state.
    logic [7:0]         track_mem [TRACK_BYTES];
    longint unsigned    track_len;
    longint unsigned    play_pos;
    longint             event_wait;
    bit                 ended;
    bit                 slot_on   [NOTE_SLOTS];
    logic [3:0]         slot_chan [NOTE_SLOTS];
    logic [7:0]         slot_key  [NOTE_SLOTS];
    longint             slot_left [NOTE_SLOTS];
    bit                 scan_done;
    int                 scan_next;
    longint unsigned    sysex_left;

    t_result            due_results [$];
    int                 fails = 0;

    assign o_fail = fails;

    function automatic longint clamp_ticks(longint x);
        if (x > DELAY_TOP) return DELAY_TOP;
        if (x < DELAY_BOTTOM) return DELAY_BOTTOM;
        return x;
    endfunction

    function automatic longint unsigned play_limit();
        return (track_len < TRACK_BYTES) ? track_len : longint'(TRACK_BYTES);
    endfunction

    // Bytes at or beyond the effective length read as zero.
    function automatic logic [7:0] track_byte(longint unsigned p);
        return (p < play_limit()) ? track_mem[p[15:0]] : 8'h00;
    endfunction

    function automatic int unsigned read_varlen();
        int unsigned v;
        logic [7:0]  b;
        v = 0;
        do begin
            b = track_byte(play_pos);
            play_pos++;
            v = (v << 7) | b[6:0];
        end while (b[7] && play_pos < play_limit());
        return v;
    endfunction

    // A gap is a run of 0x7f bytes closed by a smaller data byte; a status byte means none.
    function automatic longint read_gap();
        longint     sum;
        logic [7:0] b;
        sum = 0;
        b = track_byte(play_pos);
        if (play_pos >= play_limit() || b[7]) return 0;
        do begin
            b = track_byte(play_pos);
            if (!b[7]) begin
                sum += b;
                play_pos++;
            end
        end while (b == DATA_MASK && play_pos < play_limit());
        return sum;
    endfunction

    function automatic t_result end_track();
        t_result r;
        r = '0;
        ended = 1;
        r.kind = KIND_END;
        return r;
    endfunction

    // Works out the one result that a fetch yields.
    function automatic t_result play_fetch();
        t_result         r;
        logic [7:0]      st, d0, d1, b;
        int unsigned     ln, dur;
        longint          m;
        r = '0;
        if (ended) return end_track();
        if (!scan_done) begin
            for (int i = scan_next; i < NOTE_SLOTS; i++) begin
                if (slot_on[i] && slot_left[i] <= 0) begin
                    slot_on[i] = 0;
                    scan_next = i + 1;
                    r.kind = KIND_NOTE_OFF;
                    r.channel = slot_chan[i];
                    r.first = slot_key[i];
                    return r;
                end
            end
            scan_done = 1;
            scan_next = 0;
        end
        forever begin
            if (sysex_left > 0) begin
                b = track_byte(play_pos);
                play_pos++;
                sysex_left--;
                if (sysex_left == 0) event_wait = read_gap();
                r.kind = KIND_SYSEX;
                r.first = b;
                r.last = (sysex_left == 0);
                return r;
            end
            if (event_wait > 0) begin
                m = event_wait;
                for (int i = 0; i < NOTE_SLOTS; i++)
                    if (slot_on[i] && slot_left[i] < m) m = slot_left[i];
                if (m < 0) m = 0;
                scan_done = 0;
                r.kind = KIND_WAIT;
                r.wait_ticks = m[TICK_W-1:0];
                return r;
            end
            if (play_pos >= play_limit() || play_limit() - play_pos < HDR_BYTES)
                return end_track();
            st = track_byte(play_pos);
            play_pos++;
            d0 = track_byte(play_pos);
            play_pos++;
            case (st[7:4])
                NIB_NOTE_OFF, NIB_POLY_AT, NIB_CONTROL, NIB_PITCH: begin
                    d1 = track_byte(play_pos);
                    play_pos++;
                    event_wait = read_gap();
                    r.kind = KIND_CHAN_MSG;
                    r.channel = st[3:0];
                    r.status = st;
                    r.first = d0;
                    r.second = d1;
                    return r;
                end
                NIB_PROGRAM, NIB_CHAN_AT: begin
                    event_wait = read_gap();
                    r.kind = KIND_CHAN_MSG;
                    r.channel = st[3:0];
                    r.status = st;
                    r.first = d0;
                    return r;
                end
                NIB_NOTE_ON: begin
                    d1 = track_byte(play_pos);
                    play_pos++;
                    dur = read_varlen();
                    r.dropped = 1;
                    for (int i = 0; i < NOTE_SLOTS; i++) begin
                        if (!slot_on[i]) begin
                            slot_on[i] = 1;
                            slot_chan[i] = st[3:0];
                            slot_key[i] = d0;
                            slot_left[i] = clamp_ticks({32'b0, dur});
                            r.dropped = 0;
                            break;
                        end
                    end
                    event_wait = read_gap();
                    r.kind = KIND_NOTE_ON;
                    r.channel = st[3:0];
                    r.first = d0;
                    r.second = d1;
                    return r;
                end
                NIB_SYSTEM: begin
                    if (st != STATUS_META) begin
                        play_pos--;
                        ln = read_varlen();
                        if (play_pos + ln >= play_limit()) return end_track();
                        if (st == STATUS_SYSEX && ln > 0) begin
                            sysex_left = ln;
                            continue;
                        end
                        play_pos += ln;
                        event_wait = read_gap();
                        continue;
                    end
                    ln = read_varlen();
                    if (d0 == META_END || play_pos + ln >= play_limit()) return end_track();
                    if (d0 == META_TEMPO) begin
                        r.kind = KIND_TEMPO;
                        r.tempo = {track_byte(play_pos), track_byte(play_pos + 1),
                                   track_byte(play_pos + 2)};
                        play_pos += ln;
                        event_wait = read_gap();
                        return r;
                    end
                    play_pos += ln;
                    event_wait = read_gap();
                    continue;
                end
                default: begin
                    // Data byte where a status belongs: skipped with one data byte.
                    event_wait = read_gap();
                    continue;
                end
            endcase
        end
    endfunction

    function automatic void take_item(logic [1:0] op, logic [IN_DATA_W-1:0] d);
        longint ticks;
        case (t_func'(op))
            FUNC_LOAD: track_mem[d[15:0]] = d[23:16];
            FUNC_ADVANCE: begin
                ticks = {33'b0, d[54:24]};
                if (!ended) begin
                    event_wait = clamp_ticks(event_wait - ticks);
                    for (int i = 0; i < NOTE_SLOTS; i++)
                        if (slot_on[i]) slot_left[i] = clamp_ticks(slot_left[i] - ticks);
                end
            end
            FUNC_FETCH: due_results = {due_results, play_fetch()};
            default: begin
                // Restart: pending notes become due at once.
                play_pos = 0;
                event_wait = 0;
                ended = 0;
                for (int i = 0; i < NOTE_SLOTS; i++) slot_left[i] = 0;
                scan_done = 0;
                scan_next = 0;
                sysex_left = 0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // The result is compared before a fetch of the same edge adds its prediction.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            foreach (track_mem[i]) track_mem[i] = 8'h00;
            track_len = 0;
            play_pos = 0;
            event_wait = 0;
            ended = 0;
            for (int i = 0; i < NOTE_SLOTS; i++) begin
                slot_on[i] = 0;
                slot_chan[i] = 0;
                slot_key[i] = 0;
                slot_left[i] = 0;
            end
            scan_done = 0;
            scan_next = 0;
            sysex_left = 0;
            due_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = t_kind'(m_axis_tuser);
                got.channel = m_axis_tdata[3:0];
                got.status = m_axis_tdata[11:4];
                got.first = m_axis_tdata[19:12];
                got.second = m_axis_tdata[27:20];
                got.tempo = m_axis_tdata[51:28];
                got.wait_ticks = m_axis_tdata[82:52];
                got.dropped = m_axis_tdata[83];
                got.last = m_axis_tlast;
                if (due_results.size() == 0) begin
                    $error("result transfer with no result expected");
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("channel", want.channel, got.channel);
                    check_field("status_byte", want.status, got.status);
                    check_field("first_value", want.first, got.first);
                    check_field("second_value", want.second, got.second);
                    check_field("tempo_value", want.tempo, got.tempo);
                    check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
                    check_field("sysex_last", want.last, got.last);
                    check_field("note_dropped", want.dropped, got.dropped);
                end
            end
            if (i_cfg_valid && o_cfg_ready) track_len = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser, s_axis_tdata);
        end
        o_pending = due_results.size();
    end

endmodule

// File: bench/tb.sv
// Testbench top for the MIDI track event sequencer: builds event tracks, loads them,
// plays them with random timing and gives the verdict. Depends on mts_pkg,
// midi_track_event_sequencer and mts_scoreboard.
module tb;
    import mts_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 200;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [1:0]            s_user = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic [OUT_DATA_W-1:0] m_data;
    logic [2:0]            m_user;
    logic                  m_last;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_data = '0;
    int                    fails;
    int                    pending;

    bit                    steady = 0;
    bit                    hold_req = 0;
    bit                    hold_done = 0;
    int                    hold_left = 0;
    int                    quiet_cycles = 0;
    bit                    gap_open = 0;
    logic [7:0]            track_img [$];

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    midi_track_event_sequencer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    mts_scoreboard u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail(fails), .o_pending(pending)
    );

    // Result receiver: random stalls, one long hold-off once a result is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 0;
        end else if (hold_req && !hold_done && m_valid) begin
            hold_left <= 400;
            hold_done <= 1;
            m_ready <= 0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("midi_track_event_sequencer: mismatch");
            $finish;
        end
    end

    // One input transfer; valid stays high into the next item unless a gap is taken.
    task automatic send(t_func f, int unsigned a, int unsigned b, int unsigned t);
        if (!steady && $urandom_range(99) < 30) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1;
        s_user <= f;
        s_data <= {1'b0, t[30:0], b[7:0], a[15:0]};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_len(logic [LEN_W-1:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 0;
    endtask

    // Appends one byte to the track image.
    function automatic void add_byte(int unsigned v);
        track_img = {track_img, 8'(v)};
    endfunction

    function automatic void add_varlen(int unsigned v);
        logic [7:0] grp [$];
        grp.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0) begin
            grp.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        foreach (grp[i]) add_byte(grp[i]);
    endfunction

    function automatic void add_gap();
        int k;
        k = $urandom_range(99);
        gap_open = 0;
        if (k < 50) begin
            add_byte($urandom_range(0, 20));
        end else if (k < 70) begin
            repeat ($urandom_range(1, 2)) add_byte(DATA_MASK);
            add_byte($urandom_range(0, 126));
        end else begin
            gap_open = 1;
        end
    endfunction

    // One random event with its following gap.
    function automatic void add_event();
        int          k, n;
        logic [7:0]  st;
        k = $urandom_range(99);
        st = {4'h0, 4'($urandom_range(15))};
        if (k < 35) begin
            add_byte({NIB_NOTE_ON, st[3:0]});
            add_byte($urandom_range(127));
            add_byte($urandom_range(127));
            n = $urandom_range(99);
            if (n < 80) add_varlen($urandom_range(0, 60));
            else if (n < 95) add_varlen($urandom_range(128, 4000));
            else begin
                // Five-group duration above the delay range.
                add_byte(8'h8f);
                repeat (3) add_byte(8'hff);
                add_byte(DATA_MASK);
            end
        end else if (k < 55) begin
            case ($urandom_range(3))
                0: st[7:4] = NIB_NOTE_OFF;
                1: st[7:4] = NIB_POLY_AT;
                2: st[7:4] = NIB_CONTROL;
                default: st[7:4] = NIB_PITCH;
            endcase
            add_byte(st);
            add_byte($urandom_range(255));
            add_byte($urandom_range(255));
        end else if (k < 65) begin
            st[7:4] = $urandom_range(1) ? NIB_PROGRAM : NIB_CHAN_AT;
            add_byte(st);
            add_byte($urandom_range(255));
        end else if (k < 80) begin
            add_byte((k < 75) ? STATUS_SYSEX : 8'($urandom_range(8'hf1, 8'hfe)));
            n = $urandom_range(0, 4);
            add_varlen(n);
            repeat (n) add_byte($urandom_range(255));
        end else if (k < 88) begin
            add_byte(STATUS_META);
            add_byte(META_TEMPO);
            add_varlen(3);
            repeat (3) add_byte($urandom_range(255));
        end else if (k < 93) begin
            add_byte(STATUS_META);
            add_byte(8'h01);
            n = $urandom_range(0, 3);
            add_varlen(n);
            repeat (n) add_byte($urandom_range(255));
        end else begin
            // A data byte in status position would be read as a gap after an empty one.
            if (gap_open) add_byte(8'h00);
            add_byte($urandom_range(127));
            add_byte($urandom_range(255));
        end
        add_gap();
    endfunction

    function automatic void add_end_meta();
        add_byte(STATUS_META);
        add_byte(META_END);
        add_byte(8'h00);
    endfunction

    task automatic load_track();
        foreach (track_img[i]) send(FUNC_LOAD, i, track_img[i], $urandom);
    endtask

    task automatic advance_random();
        int k;
        k = $urandom_range(99);
        if (k < 70) send(FUNC_ADVANCE, $urandom, $urandom, $urandom_range(0, 200));
        else if (k < 90) send(FUNC_ADVANCE, $urandom, $urandom, $urandom_range(0, 32767));
        else if (k < 95) send(FUNC_ADVANCE, $urandom, $urandom, 31'h7fffffff);
        else send(FUNC_ADVANCE, $urandom, $urandom, $urandom);
    endtask

    // Playback traffic; stray loads only touch bytes past the track image.
    task automatic play(int n);
        int k;
        repeat (n) begin
            k = $urandom_range(99);
            if (k < 60) send(FUNC_FETCH, $urandom, $urandom, $urandom);
            else if (k < 88) advance_random();
            else if (k < 91) send(FUNC_RESTART, $urandom, $urandom, $urandom);
            else send(FUNC_LOAD, $urandom_range(track_img.size(), 65535), $urandom, $urandom);
        end
    endtask

    // len_mode: 0 image size or a little less, 1 largest register value, 2 full memory.
    task automatic run_phase(int n_ev, int n_play, int len_mode);
        int cut;
        track_img.delete();
        gap_open = 0;
        repeat (n_ev) add_event();
        if (len_mode != 0 || $urandom_range(1)) add_end_meta();
        load_track();
        drain();
        cut = $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0;
        if (len_mode == 1) write_len(17'h1ffff);
        else if (len_mode == 2) write_len(17'h10000);
        else write_len(track_img.size() > cut ? LEN_W'(track_img.size() - cut) : '0);
        send(FUNC_RESTART, $urandom, $urandom, $urandom);
        play(n_play);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty track: every fetch ends, advance is ignored, restart reopens it.
        write_len(0);
        send(FUNC_FETCH, 0, 0, 0);
        send(FUNC_ADVANCE, 16'hffff, 8'hff, 31'h7fffffff);
        send(FUNC_RESTART, 0, 0, 0);
        send(FUNC_FETCH, 16'hffff, 8'hff, 31'h7fffffff);
        send(FUNC_LOAD, 16'hffff, 8'hff, 0);
        drain();

        // Directed track: every event form, empty sysex, skipped events, short tail.
        track_img = '{8'h00,
                      8'h90, 8'h3c, 8'h64, 8'h0a, 8'h00,
                      8'h85, 8'h40, 8'h7f, 8'h05,
                      8'hc3, 8'h12, 8'h00,
                      8'hd1, 8'h7f, 8'h00,
                      8'h9f, 8'h7f, 8'h7f, 8'h8f, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00,
                      8'hf0, 8'h02, 8'h11, 8'h22, 8'h7f, 8'h03,
                      8'hf0, 8'h00,
                      8'hf3, 8'h01, 8'h55,
                      8'hff, 8'h01, 8'h02, 8'h41, 8'h42,
                      8'hff, 8'h51, 8'h03, 8'h07, 8'ha1, 8'h20, 8'h00,
                      8'h40, 8'h11, 8'h00,
                      8'he2, 8'h00, 8'h40, 8'h00,
                      8'hb0, 8'h07};
        load_track();
        drain();
        write_len(LEN_W'(track_img.size()));
        send(FUNC_RESTART, 0, 0, 0);
        repeat (6) send(FUNC_FETCH, 0, 0, 0);
        send(FUNC_ADVANCE, 0, 0, 12);
        repeat (8) send(FUNC_FETCH, 0, 0, 0);
        send(FUNC_ADVANCE, 0, 0, 200);
        repeat (10) send(FUNC_FETCH, 0, 0, 0);
        drain();

        // More note-ons than slots: the overflow is flagged and never released.
        track_img.delete();
        repeat (NOTE_SLOTS + 2) begin
            add_byte({NIB_NOTE_ON, 4'($urandom_range(15))});
            add_byte($urandom_range(127));
            add_byte($urandom_range(127));
            add_byte(8'h40);
        end
        add_end_meta();
        load_track();
        drain();
        write_len(LEN_W'(track_img.size()));
        send(FUNC_RESTART, 0, 0, 0);
        repeat (NOTE_SLOTS + 4) send(FUNC_FETCH, 0, 0, 0);
        send(FUNC_ADVANCE, 0, 0, 8'h40);
        repeat (4) send(FUNC_FETCH, 0, 0, 0);
        drain();

        // Random tracks.
        run_phase(8, 30, 0);
        steady = 1;
        run_phase(6, 25, 1);
        drain();
        steady = 0;
        hold_req <= 1;
        run_phase(8, 30, 2);
        drain();

        if (fails == 0)
            $display("midi_track_event_sequencer: match");
        else
            $display("midi_track_event_sequencer: mismatch");
        $finish;
    end

endmodule
